>>> rtl/speed_limit_pid_governor_assert.svh
// ----------------------------------------------------------------------------
// speed limit pid governor assertion macros
// concurrent checks that fall away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef SPEED_LIMIT_PID_GOVERNOR_ASSERT_SVH
`define SPEED_LIMIT_PID_GOVERNOR_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SLPG_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("slpg: %m check failed");
// next-cycle implication
`define SLPG_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("slpg: %m check failed");
`else
`define SLPG_ASSERT_IMP(label, clk, rstn, ante, cons)
`define SLPG_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/slpg_pkg.sv
// ----------------------------------------------------------------------------
// slpg_pkg
// shared widths, constants and types of the speed limit pid governor
// ----------------------------------------------------------------------------
package slpg_pkg;

    // field widths
    localparam int KPH_W      = 8;
    localparam int REQ_W      = 8;
    localparam int GAIN_W     = 16;
    localparam int TIME_W     = 32;
    localparam int ELAP_W     = 16;
    localparam int SPD_W      = 15;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_SPEED   = 3'd0,
        CFG_GAIN_P      = 3'd1,
        CFG_GAIN_I      = 3'd2,
        CFG_GAIN_D      = 3'd3,
        CFG_LOOP_PERIOD = 3'd4,
        CFG_RESTART_GAP = 3'd5
    } cfg_idx_t;

    // fixed point
    localparam int INTEG_FRAC = 16;
    localparam int INTEG_W    = REQ_W + INTEG_FRAC;
    localparam int OPND_W     = SPD_W + 2;
    localparam int PROD_W     = GAIN_W + OPND_W;
    localparam int SUM_W      = PROD_W + 2;

    // kph to rpm: floor(kph * RPM_NUM / RPM_DEN) through a reciprocal
    localparam int    WHEEL_CIRC_MM = 2268;
    localparam longint RPM_NUM      = 100000;
    localparam longint RPM_DEN      = longint'(WHEEL_CIRC_MM) * 6;
    localparam int    RPM_SHIFT     = 24;
    localparam longint RPM_RECIP    =
        ((longint'(1) << RPM_SHIFT) * RPM_NUM + RPM_DEN - 1) / RPM_DEN;
    localparam int    RECIP_W       = $clog2(RPM_RECIP + 1);
    localparam int    CONV_ACC_W    = KPH_W + RECIP_W;
    localparam int    RPM_W         = CONV_ACC_W - RPM_SHIFT;
    localparam int    RPM_SAT       = 3276;
    localparam int    SPD_MAX       = 32767;

    // sequencing counter covers the longest serial pass
    localparam int CNT_W = $clog2(GAIN_W);

    // reset values
    localparam int RST_MAX_SPEED   = 25;
    localparam int RST_GAIN_P      = 6554;
    localparam int RST_GAIN_I      = 262;
    localparam int RST_GAIN_D      = 655;
    localparam int RST_LOOP_PERIOD = 60;
    localparam int RST_RESTART_GAP = 2000;
    localparam int RST_LAST_EVAL   = 50;

    // control of a serial unit
    typedef struct packed {
        logic load;
        logic step;
    } slpg_ser_ctl_t;

endpackage

>>> rtl/slpg_rpm_conv.sv
// ----------------------------------------------------------------------------
// slpg_rpm_conv
// bit-serial kph to rpm x10 converter, one kph bit per cycle while ctl.step is high, msb first
// ----------------------------------------------------------------------------
module slpg_rpm_conv (
    input  logic                           aclk,
    input  slpg_pkg::slpg_ser_ctl_t        ctl,
    input  logic [slpg_pkg::KPH_W-1:0]     kph,
    output logic [slpg_pkg::SPD_W-1:0]     rpm_x10
);
    import slpg_pkg::*;

    localparam logic [CONV_ACC_W-1:0] RECIP = CONV_ACC_W'(RPM_RECIP);

    logic [KPH_W-1:0]      digit_reg, digit_next;
    logic [CONV_ACC_W-1:0] acc_reg, acc_next;
    logic [RPM_W-1:0]      rpm;
    logic [RPM_W+3:0]      x10_wide;

    always_comb begin
        digit_next = digit_reg;
        acc_next   = acc_reg;
        if (ctl.load) begin
            digit_next = kph;
            acc_next   = '0;
        end else if (ctl.step) begin
            acc_next   = {acc_reg[CONV_ACC_W-2:0], 1'b0}
                       + (digit_reg[KPH_W-1] ? RECIP : '0);
            digit_next = {digit_reg[KPH_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
        acc_reg   <= acc_next;
    end

    assign rpm      = acc_reg[CONV_ACC_W-1:RPM_SHIFT];
    // times ten as eight plus two
    assign x10_wide = {1'b0, rpm, 3'b000} + {3'b000, rpm, 1'b0};

    always_comb begin
        if ((32'(rpm) > 32'(RPM_SAT)) || (32'(x10_wide) > 32'(SPD_MAX))) begin
            rpm_x10 = SPD_W'(SPD_MAX);
        end else begin
            rpm_x10 = SPD_W'(x10_wide);
        end
    end

endmodule

>>> rtl/slpg_ser_mul.sv
// ----------------------------------------------------------------------------
// slpg_ser_mul
// bit-serial multiplier: unsigned gain times signed operand, gain msb first
// ----------------------------------------------------------------------------
module slpg_ser_mul (
    input  logic                                aclk,
    input  slpg_pkg::slpg_ser_ctl_t             ctl,
    input  logic        [slpg_pkg::GAIN_W-1:0]  gain,
    input  logic signed [slpg_pkg::OPND_W-1:0]  opnd,
    output logic signed [slpg_pkg::PROD_W-1:0]  prod
);
    import slpg_pkg::*;

    logic [GAIN_W-1:0]        gain_reg, gain_next;
    logic signed [OPND_W-1:0] opnd_reg, opnd_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [PROD_W-1:0] opnd_ext;

    assign opnd_ext = {{GAIN_W{opnd_reg[OPND_W-1]}}, opnd_reg};

    always_comb begin
        gain_next = gain_reg;
        opnd_next = opnd_reg;
        prod_next = prod_reg;
        if (ctl.load) begin
            gain_next = gain;
            opnd_next = opnd;
            prod_next = '0;
        end else if (ctl.step) begin
            prod_next = {prod_reg[PROD_W-2:0], 1'b0}
                      + (gain_reg[GAIN_W-1] ? opnd_ext : '0);
            gain_next = {gain_reg[GAIN_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        gain_reg <= gain_next;
        opnd_reg <= opnd_next;
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

>>> rtl/speed_limit_pid_governor.sv
// ----------------------------------------------------------------------------
// speed_limit_pid_governor
// pid speed governor that limits a requested motor current
// ----------------------------------------------------------------------------
// usage
//   input words (s_ channel) carry time, requested current and wheel speed;
//   each gives exactly one result word on the m_ channel, in order.
//   registers are to be written through cfg_wr_en / cfg_index / cfg_wdata
//   only while the block is idle, a rule on the user that the block itself
//   does not enforce; unknown indexes are ignored.
//   a word with no pid step due (limit or request zero, or loop period not
//   yet elapsed) goes from acceptance straight to the result stage.
//   a word that runs a pid step passes the two bit-serial speed converters,
//   setup, the three bit-serial gain multipliers, the integrator update and
//   the sum before it reaches the result stage.
//   one word is worked on at a time; the result sits in an output register,
//   so the next word is taken while the receiver stalls, and only a finished
//   second result waits for that register to drain.
//   reset (aresetn low, synchronous) restores the register defaults, clears
//   the integrator, held output and previous speed, and sets the last step
//   time to 50 ms; no word is taken while reset is held.
// ----------------------------------------------------------------------------
`include "speed_limit_pid_governor_assert.svh"

module speed_limit_pid_governor (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [slpg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [slpg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [slpg_pkg::TIME_W-1:0]        s_now_ms,
    input  logic [slpg_pkg::REQ_W-1:0]         s_requested_current,
    input  logic [slpg_pkg::KPH_W-1:0]         s_speed_kph,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [slpg_pkg::REQ_W-1:0]         m_limited_current,
    output logic                               m_limiting
);
    import slpg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_PREP,
        ST_MUL,
        ST_INTEG,
        ST_SUM,
        ST_DONE
    } state_t;

    localparam logic signed [SUM_W-1:0] ONE_Q = SUM_W'(64'd1 << INTEG_FRAC);
    localparam int WHOLE_W = SUM_W - INTEG_FRAC;

    // configuration
    logic [KPH_W-1:0]  max_speed_reg, max_speed_next;
    logic [GAIN_W-1:0] gain_p_reg, gain_p_next;
    logic [GAIN_W-1:0] gain_i_reg, gain_i_next;
    logic [GAIN_W-1:0] gain_d_reg, gain_d_next;
    logic [ELAP_W-1:0] loop_period_reg, loop_period_next;
    logic [ELAP_W-1:0] restart_gap_reg, restart_gap_next;

    // control and controller state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TIME_W-1:0] last_eval_reg, last_eval_next;
    logic [SPD_W-1:0]  prev_rpm_reg, prev_rpm_next;
    logic [REQ_W-1:0]  held_reg, held_next;
    logic [INTEG_W-1:0] integ_reg, integ_next;
    logic              m_valid_reg, m_valid_next;

    // payload
    logic [TIME_W-1:0] now_reg, now_next;
    logic [REQ_W-1:0]  req_reg, req_next;
    logic              restart_reg, restart_next;
    logic [REQ_W-1:0]  res_cur_reg, res_cur_next;
    logic              res_lim_reg, res_lim_next;
    logic [REQ_W-1:0]  m_cur_reg, m_cur_next;
    logic              m_lim_reg, m_lim_next;

    // datapath
    slpg_ser_ctl_t             conv_ctl, mul_ctl;
    logic [SPD_W-1:0]          limit_x10, speed_x10;
    logic signed [OPND_W-1:0]  err, d_input;
    logic signed [PROD_W-1:0]  prod_p, prod_i, prod_d;
    logic [ELAP_W-1:0]         elapsed;
    logic                      active, due, restart, hold_lim;
    logic [INTEG_W-1:0]        integ_top;
    logic signed [SUM_W-1:0]   integ_acc, pid_sum;
    logic [WHOLE_W-1:0]        whole;
    logic [REQ_W-1:0]          held_new;
    logic                      lim_new;

    slpg_rpm_conv u_conv_limit (
        .aclk    (aclk),
        .ctl     (conv_ctl),
        .kph     (max_speed_reg),
        .rpm_x10 (limit_x10)
    );

    slpg_rpm_conv u_conv_speed (
        .aclk    (aclk),
        .ctl     (conv_ctl),
        .kph     (s_speed_kph),
        .rpm_x10 (speed_x10)
    );

    slpg_ser_mul u_mul_p (
        .aclk (aclk),
        .ctl  (mul_ctl),
        .gain (gain_p_reg),
        .opnd (err),
        .prod (prod_p)
    );

    slpg_ser_mul u_mul_i (
        .aclk (aclk),
        .ctl  (mul_ctl),
        .gain (gain_i_reg),
        .opnd (err),
        .prod (prod_i)
    );

    slpg_ser_mul u_mul_d (
        .aclk (aclk),
        .ctl  (mul_ctl),
        .gain (gain_d_reg),
        .opnd (d_input),
        .prod (prod_d)
    );

    // admission checks, on the word at the input
    assign elapsed  = s_now_ms[ELAP_W-1:0] - last_eval_reg[ELAP_W-1:0];
    assign active   = (max_speed_reg != '0) && (s_requested_current != '0);
    assign due      = elapsed >= loop_period_reg;
    assign restart  = elapsed >= restart_gap_reg;
    assign hold_lim = active && (s_requested_current > held_reg);

    // pid operands
    assign err     = $signed({2'b00, limit_x10}) - $signed({2'b00, speed_x10});
    assign d_input = restart_reg ? '0
                   : $signed({2'b00, speed_x10}) - $signed({2'b00, prev_rpm_reg});

    assign integ_top = {req_reg, {INTEG_FRAC{1'b0}}};
    assign integ_acc = $signed({{(SUM_W-INTEG_W){1'b0}}, integ_reg})
                     + $signed({{(SUM_W-PROD_W){prod_i[PROD_W-1]}}, prod_i});
    assign pid_sum   = $signed({{(SUM_W-PROD_W){prod_p[PROD_W-1]}}, prod_p})
                     + $signed({{(SUM_W-INTEG_W){1'b0}}, integ_reg})
                     - $signed({{(SUM_W-PROD_W){prod_d[PROD_W-1]}}, prod_d});
    assign whole     = pid_sum[SUM_W-1:INTEG_FRAC];

    // truncation toward zero then clamp: anything below one whole unit gives one
    always_comb begin
        if (pid_sum < ONE_Q) begin
            held_new = REQ_W'(1);
        end else if (whole > WHOLE_W'(req_reg)) begin
            held_new = req_reg;
        end else begin
            held_new = REQ_W'(whole);
        end
    end
    assign lim_new = req_reg > held_new;

    always_comb begin
        max_speed_next   = max_speed_reg;
        gain_p_next      = gain_p_reg;
        gain_i_next      = gain_i_reg;
        gain_d_next      = gain_d_reg;
        loop_period_next = loop_period_reg;
        restart_gap_next = restart_gap_reg;
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        last_eval_next   = last_eval_reg;
        prev_rpm_next    = prev_rpm_reg;
        held_next        = held_reg;
        integ_next       = integ_reg;
        now_next         = now_reg;
        req_next         = req_reg;
        restart_next     = restart_reg;
        res_cur_next     = res_cur_reg;
        res_lim_next     = res_lim_reg;
        m_cur_next       = m_cur_reg;
        m_lim_next       = m_lim_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        conv_ctl         = '0;
        mul_ctl          = '0;
        s_ready          = 1'b0;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MAX_SPEED:   max_speed_next   = cfg_wdata[KPH_W-1:0];
                CFG_GAIN_P:      gain_p_next      = cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_I:      gain_i_next      = cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_D:      gain_d_next      = cfg_wdata[GAIN_W-1:0];
                CFG_LOOP_PERIOD: loop_period_next = cfg_wdata[ELAP_W-1:0];
                CFG_RESTART_GAP: restart_gap_next = cfg_wdata[ELAP_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                // nothing is taken while reset is held
                s_ready = aresetn;
                if (s_valid) begin
                    now_next     = s_now_ms;
                    req_next     = s_requested_current;
                    restart_next = restart;
                    if (active && due) begin
                        conv_ctl.load = 1'b1;
                        cnt_next      = '0;
                        state_next    = ST_CONV;
                    end else begin
                        res_cur_next = hold_lim ? held_reg : s_requested_current;
                        res_lim_next = hold_lim;
                        state_next   = ST_DONE;
                    end
                end
            end
            ST_CONV: begin
                conv_ctl.step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(KPH_W - 1)) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                mul_ctl.load = 1'b1;
                cnt_next     = '0;
                if (restart_reg) begin
                    integ_next = integ_top;
                end
                state_next = ST_MUL;
            end
            ST_MUL: begin
                mul_ctl.step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(GAIN_W - 1)) begin
                    state_next = ST_INTEG;
                end
            end
            ST_INTEG: begin
                if (integ_acc < 0) begin
                    integ_next = '0;
                end else if (integ_acc > $signed({{(SUM_W-INTEG_W){1'b0}}, integ_top})) begin
                    integ_next = integ_top;
                end else begin
                    integ_next = integ_acc[INTEG_W-1:0];
                end
                state_next = ST_SUM;
            end
            ST_SUM: begin
                held_next      = held_new;
                prev_rpm_next  = speed_x10;
                last_eval_next = now_reg;
                res_cur_next   = lim_new ? held_new : req_reg;
                res_lim_next   = lim_new;
                state_next     = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_cur_next   = res_cur_reg;
                    m_lim_next   = res_lim_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg   <= KPH_W'(RST_MAX_SPEED);
            gain_p_reg      <= GAIN_W'(RST_GAIN_P);
            gain_i_reg      <= GAIN_W'(RST_GAIN_I);
            gain_d_reg      <= GAIN_W'(RST_GAIN_D);
            loop_period_reg <= ELAP_W'(RST_LOOP_PERIOD);
            restart_gap_reg <= ELAP_W'(RST_RESTART_GAP);
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            last_eval_reg   <= TIME_W'(RST_LAST_EVAL);
            prev_rpm_reg    <= '0;
            held_reg        <= '0;
            integ_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            max_speed_reg   <= max_speed_next;
            gain_p_reg      <= gain_p_next;
            gain_i_reg      <= gain_i_next;
            gain_d_reg      <= gain_d_next;
            loop_period_reg <= loop_period_next;
            restart_gap_reg <= restart_gap_next;
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            last_eval_reg   <= last_eval_next;
            prev_rpm_reg    <= prev_rpm_next;
            held_reg        <= held_next;
            integ_reg       <= integ_next;
            m_valid_reg     <= m_valid_next;
        end
        now_reg     <= now_next;
        req_reg     <= req_next;
        restart_reg <= restart_next;
        res_cur_reg <= res_cur_next;
        res_lim_reg <= res_lim_next;
        m_cur_reg   <= m_cur_next;
        m_lim_reg   <= m_lim_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_limited_current = m_cur_reg;
    assign m_limiting        = m_lim_reg;

    `SLPG_ASSERT_NXT(a_integ_in_range, aclk, aresetn, state_reg == ST_INTEG, integ_reg <= integ_top)
    `SLPG_ASSERT_NXT(a_held_in_range, aclk, aresetn, state_reg == ST_SUM, (held_reg >= REQ_W'(1)) && (held_reg <= req_reg))
    `SLPG_ASSERT_NXT(a_result_moves_out, aclk, aresetn, (state_reg == ST_DONE) && (!m_valid_reg || m_ready), m_valid_reg && (state_reg == ST_IDLE))
    `SLPG_ASSERT_IMP(a_ready_only_idle, aclk, aresetn, s_ready, (state_reg == ST_IDLE) && !conv_ctl.step && !mul_ctl.step)

endmodule
